// ===== rtl/awp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awp_pkg
// Shared widths, register indexes, reset values and the divider request type
// of the autoscaled strip chart plotter.
// ----------------------------------------------------------------------------
package awp_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int LEVEL_BITS     = 3;
   localparam int PIXEL_BITS     = 8;
   localparam int X_END_BITS     = 9;
   localparam int QUO_BITS       = 8;
   localparam int NUM_BITS       = SAMPLE_BITS + QUO_BITS;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SPAN    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALARM_LEVEL = 1'd1;

   localparam logic [SAMPLE_BITS-1:0] MIN_SPAN_RESET    = 12'd20;
   localparam logic [LEVEL_BITS-1:0]  ALARM_LEVEL_RESET = 3'd3;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] num;
      sample_type          den;
   } div_req_type;

endpackage
`default_nettype wire

// ===== rtl/awp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awp channel interfaces
// Valid/ready channels for sample transactions and segment transactions.
// ----------------------------------------------------------------------------
interface awp_req_if;
   logic                             valid;
   logic                             ready;
   logic [awp_pkg::SAMPLE_BITS-1:0]  sample;
   logic [awp_pkg::LEVEL_BITS-1:0]   alert_level;

   modport source (output valid, output sample, output alert_level, input ready);
   modport sink   (input valid, input sample, input alert_level, output ready);
endinterface

interface awp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [awp_pkg::PIXEL_BITS-1:0]   x_start;
   logic [awp_pkg::PIXEL_BITS-1:0]   y_start;
   logic [awp_pkg::X_END_BITS-1:0]   x_end;
   logic [awp_pkg::PIXEL_BITS-1:0]   y_end;
   logic                             alarm_colour;
   logic [awp_pkg::SAMPLE_BITS-1:0]  window_max;
   logic [awp_pkg::SAMPLE_BITS-1:0]  window_min;
   logic                             segment_valid;
   logic                             last_segment;

   modport source (output valid, output x_start, output y_start, output x_end,
                   output y_end, output alarm_colour, output window_max,
                   output window_min, output segment_valid, output last_segment,
                   input ready);
   modport sink   (input valid, input x_start, input y_start, input x_end,
                   input y_end, input alarm_colour, input window_max,
                   input window_min, input segment_valid, input last_segment,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/awp_history.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awp_history
// Sample ring memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module awp_history #(
   parameter int DEPTH = 60,
   parameter int AW    = 6
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire awp_pkg::sample_type    wr_data,
   input  wire logic                   rd_en,
   input  wire logic [AW-1:0]          rd_addr,
   output      awp_pkg::sample_type    rd_data
);

   awp_pkg::sample_type mem_ff [DEPTH];
   awp_pkg::sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/awp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awp_divider
// Restoring divider, one quotient bit per cycle: load on start, then one
// subtract-and-shift step per quotient bit; done pulses the cycle after the last bit.
// The caller guarantees the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module awp_divider #(
   parameter int QUO_W = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire awp_pkg::div_req_type          req,
   output      logic [awp_pkg::QUO_BITS-1:0]  quo,
   output      logic                          done
);

   localparam int CW = $clog2(QUO_W + 1);

   logic [awp_pkg::NUM_BITS-1:0] rem_ff, rem_in;
   logic [awp_pkg::NUM_BITS-1:0] den_ff, den_in;
   logic [awp_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic                         fits;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      fits    = rem_ff >= den_ff;
      if (req.start) begin
         rem_in = req.num;
         den_in = awp_pkg::NUM_BITS'(req.den) << (QUO_W - 1);
         quo_in = '0;
         cnt_in = CW'(QUO_W);
      end else if (cnt_ff != '0) begin
         // subtract the aligned divisor when it fits, shift in the bit
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quo_in  = {quo_ff[awp_pkg::QUO_BITS-2:0], fits};
         den_in  = den_ff >> 1;
         cnt_in  = cnt_ff - CW'(1);
         done_in = cnt_ff == CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/autoscaled_waveform_plotter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// autoscaled_waveform_plotter_unit
// Rolling strip chart: stores each sample in a ring memory, scans the stored
// window for minimum and maximum, then emits one scaled line segment per
// adjacent sample pair, oldest first; a lone sample gives one segment-free result.
// ----------------------------------------------------------------------------
// Sequence: with N stored samples (N after the write), the scan reads all N,
//   the span is registered, then each sample in turn is read and scaled by
//   the divider to Q bits ($clog2(PLOT_HEIGHT+1), 8 by default).
// Flow: one transaction at a time; a new sample is accepted only in idle,
//   once the last result of the previous one is registered; the pace is set
//   by the single bit-serial divider that scales every sample once.
// Reset: synchronous; empties the history (fill count zero) and loads the
//   register reset values. No clearing pass over the memory is needed.
// ----------------------------------------------------------------------------
module autoscaled_waveform_plotter_unit #(
   parameter int DEPTH       = 60,
   parameter int X_STEP      = 4,
   parameter int PLOT_TOP    = 42,
   parameter int PLOT_HEIGHT = 160
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   awp_req_if.sink                                  req,
   awp_rsp_if.source                                rsp,
   input  wire logic                                csr_wr_en,
   input  wire logic [awp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [awp_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int AW     = $clog2(DEPTH);
   localparam int FW     = $clog2(DEPTH + 1);
   localparam int QW     = $clog2(PLOT_HEIGHT + 1);
   localparam int Y_W    = 10;
   localparam int Y_BASE = PLOT_TOP + PLOT_HEIGHT;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SPAN,
      ST_READ,
      ST_SCALE,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Configuration registers
   awp_pkg::sample_type                  min_span_ff;
   logic [awp_pkg::LEVEL_BITS-1:0]       alarm_level_ff;

   // Sequencer state
   state_type                            state_ff, state_in;
   logic [AW-1:0]                        wp_ff, wp_in;
   logic [FW-1:0]                        fill_ff, fill_in;
   logic [AW-1:0]                        base_ff, base_in;
   logic [AW-1:0]                        addr_ff, addr_in;
   logic [FW-1:0]                        cnt_ff, cnt_in;
   logic                                 pend_ff, pend_in;
   awp_pkg::sample_type                  lo_ff, lo_in;
   awp_pkg::sample_type                  hi_ff, hi_in;
   awp_pkg::sample_type                  span_ff, span_in;
   logic                                 alarm_ff, alarm_in;
   logic [awp_pkg::PIXEL_BITS-1:0]       prev_y_ff, prev_y_in;
   logic [awp_pkg::PIXEL_BITS-1:0]       cur_y_ff, cur_y_in;
   logic [awp_pkg::X_END_BITS-1:0]       x_ff, x_in;

   // Result register
   logic                                 out_valid_ff, out_valid_in;
   logic [awp_pkg::PIXEL_BITS-1:0]       out_x_start_ff, out_x_start_in;
   logic [awp_pkg::PIXEL_BITS-1:0]       out_y_start_ff, out_y_start_in;
   logic [awp_pkg::X_END_BITS-1:0]       out_x_end_ff, out_x_end_in;
   logic [awp_pkg::PIXEL_BITS-1:0]       out_y_end_ff, out_y_end_in;
   logic                                 out_alarm_ff, out_alarm_in;
   awp_pkg::sample_type                  out_max_ff, out_max_in;
   awp_pkg::sample_type                  out_min_ff, out_min_in;
   logic                                 out_seg_ff, out_seg_in;
   logic                                 out_last_ff, out_last_in;

   // Memory and divider hookup
   logic                                 mem_wr_en;
   logic                                 mem_rd_en;
   logic [AW-1:0]                        mem_rd_addr;
   awp_pkg::sample_type                  mem_rd_data;
   awp_pkg::div_req_type                 div_req;
   logic [awp_pkg::QUO_BITS-1:0]         div_quo;
   logic                                 div_done;

   // Helpers
   logic                                 accept;
   logic                                 out_free;
   logic                                 scan_issue;
   logic                                 last_pair;
   awp_pkg::sample_type                  eff_min_span;
   awp_pkg::sample_type                  diff;
   awp_pkg::sample_type                  delta;
   logic [awp_pkg::PIXEL_BITS-1:0]       y_calc;

   function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
      logic [AW-1:0] r;
      r = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
      return r;
   endfunction

   awp_history #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req.sample),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   awp_divider #(
      .QUO_W (QW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign req.ready = state_ff == ST_IDLE;
   assign accept    = req.valid && req.ready;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign mem_wr_en = accept;

   // Scan issues one read per stored sample, oldest first
   assign scan_issue = (state_ff == ST_SCAN) && (cnt_ff != fill_ff);
   assign mem_rd_en  = scan_issue || (state_ff == ST_READ);
   assign mem_rd_addr = addr_ff;

   // Span: max - min, floored at min_span (zero counts as one)
   assign eff_min_span = (min_span_ff == '0) ? awp_pkg::SAMPLE_BITS'(1) : min_span_ff;
   assign diff         = hi_ff - lo_ff;

   // Scale input: offset from the window minimum times the plot height
   assign delta        = (mem_rd_data >= lo_ff) ? mem_rd_data - lo_ff : '0;
   assign div_req.start = state_ff == ST_SCALE;
   assign div_req.num   = awp_pkg::NUM_BITS'(delta) * awp_pkg::NUM_BITS'(PLOT_HEIGHT);
   assign div_req.den   = span_ff;

   // Screen y grows downward: top + height - scaled value
   assign y_calc    = awp_pkg::PIXEL_BITS'(Y_W'(Y_BASE) - Y_W'(div_quo));
   assign last_pair = (cnt_ff + FW'(1)) == fill_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      span_in      = span_ff;
      alarm_in     = alarm_ff;
      prev_y_in    = prev_y_ff;
      cur_y_in     = cur_y_ff;
      x_in         = x_ff;

      out_valid_in   = out_valid_ff && !rsp.ready;
      out_x_start_in = out_x_start_ff;
      out_y_start_in = out_y_start_ff;
      out_x_end_in   = out_x_end_ff;
      out_y_end_in   = out_y_end_ff;
      out_alarm_in   = out_alarm_ff;
      out_max_in     = out_max_ff;
      out_min_in     = out_min_ff;
      out_seg_in     = out_seg_ff;
      out_last_in    = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Store the sample, advance the ring, locate the oldest entry
               wp_in    = next_addr(wp_ff);
               fill_in  = (fill_ff == FW'(DEPTH)) ? fill_ff : fill_ff + FW'(1);
               base_in  = (fill_in == FW'(DEPTH)) ? wp_in : '0;
               addr_in  = base_in;
               cnt_in   = '0;
               lo_in    = '1;
               hi_in    = '0;
               alarm_in = req.alert_level >= alarm_level_ff;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               addr_in = next_addr(addr_ff);
               cnt_in  = cnt_ff + FW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (mem_rd_data < lo_ff) begin
                  lo_in = mem_rd_data;
               end
               if (mem_rd_data > hi_ff) begin
                  hi_in = mem_rd_data;
               end
            end
            if (!scan_issue && !pend_ff) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            span_in = (diff < eff_min_span) ? eff_min_span : diff;
            addr_in = base_ff;
            cnt_in  = '0;
            x_in    = '0;
            if (fill_ff == FW'(1)) begin
               // Lone first sample: one result without a segment
               if (out_free) begin
                  out_valid_in   = 1'b1;
                  out_x_start_in = '0;
                  out_y_start_in = '0;
                  out_x_end_in   = '0;
                  out_y_end_in   = '0;
                  out_alarm_in   = alarm_ff;
                  out_max_in     = hi_ff;
                  out_min_in     = lo_ff;
                  out_seg_in     = 1'b0;
                  out_last_in    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            addr_in  = next_addr(addr_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               cur_y_in = y_calc;
               if (cnt_ff == '0) begin
                  // Oldest sample only opens the first segment
                  prev_y_in = y_calc;
                  cnt_in    = FW'(1);
                  state_in  = ST_READ;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_x_start_in = x_ff[awp_pkg::PIXEL_BITS-1:0];
               out_y_start_in = prev_y_ff;
               out_x_end_in   = x_ff + awp_pkg::X_END_BITS'(X_STEP);
               out_y_end_in   = cur_y_ff;
               out_alarm_in   = alarm_ff;
               out_max_in     = hi_ff;
               out_min_in     = lo_ff;
               out_seg_in     = 1'b1;
               out_last_in    = last_pair;
               prev_y_in      = cur_y_ff;
               x_in           = x_ff + awp_pkg::X_END_BITS'(X_STEP);
               cnt_in         = cnt_ff + FW'(1);
               state_in       = last_pair ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wp_ff          <= '0;
         fill_ff        <= '0;
         pend_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
         min_span_ff    <= awp_pkg::MIN_SPAN_RESET;
         alarm_level_ff <= awp_pkg::ALARM_LEVEL_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               awp_pkg::CSR_MIN_SPAN: begin
                  min_span_ff <= csr_wr_data[awp_pkg::SAMPLE_BITS-1:0];
               end
               awp_pkg::CSR_ALARM_LEVEL: begin
                  alarm_level_ff <= csr_wr_data[awp_pkg::LEVEL_BITS-1:0];
               end
               default: begin
                  min_span_ff <= min_span_ff;
               end
            endcase
         end
      end
      base_ff        <= base_in;
      addr_ff        <= addr_in;
      cnt_ff         <= cnt_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      span_ff        <= span_in;
      alarm_ff       <= alarm_in;
      prev_y_ff      <= prev_y_in;
      cur_y_ff       <= cur_y_in;
      x_ff           <= x_in;
      out_x_start_ff <= out_x_start_in;
      out_y_start_ff <= out_y_start_in;
      out_x_end_ff   <= out_x_end_in;
      out_y_end_ff   <= out_y_end_in;
      out_alarm_ff   <= out_alarm_in;
      out_max_ff     <= out_max_in;
      out_min_ff     <= out_min_in;
      out_seg_ff     <= out_seg_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.x_start       = out_x_start_ff;
   assign rsp.y_start       = out_y_start_ff;
   assign rsp.x_end         = out_x_end_ff;
   assign rsp.y_end         = out_y_end_ff;
   assign rsp.alarm_colour  = out_alarm_ff;
   assign rsp.window_max    = out_max_ff;
   assign rsp.window_min    = out_min_ff;
   assign rsp.segment_valid = out_seg_ff;
   assign rsp.last_segment  = out_last_ff;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the autoscaled strip chart plotter. A queue-fed
// driver pushes sample transactions into the block. A scoreboard rebuilds
// the ring history, the window extremes, the span floor and the scaled
// segments, and a monitor compares every segment transaction against it. Four
// phases of varied idling use register settings that include the extremes.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HIST_DEPTH    = 60;
   localparam int X_STEP        = 4;
   localparam int PLOT_TOP      = 42;
   localparam int PLOT_HEIGHT   = 160;
   localparam int SAMPLE_MAX    = (1 << awp_pkg::SAMPLE_BITS) - 1;
   localparam int QUIET_LIMIT   = 20000;  // cycles without any transaction
   localparam int DRAIN_CYCLES  = 1000;   // above one full-window pass
   localparam int ITEMS_PER_RUN = 77;     // samples per phase

   // Shapes of the random sample bursts.
   typedef enum int {
      WAVE_RANDOM,
      WAVE_NOISE,
      WAVE_RAMP,
      WAVE_FLAT,
      WAVE_SQUARE
   } wave_kind_type;

   typedef struct {
      awp_pkg::sample_type            sample;
      logic [awp_pkg::LEVEL_BITS-1:0] alert_level;
   } sample_item_type;

   typedef struct {
      logic [awp_pkg::PIXEL_BITS-1:0]  x_start;
      logic [awp_pkg::PIXEL_BITS-1:0]  y_start;
      logic [awp_pkg::X_END_BITS-1:0]  x_end;
      logic [awp_pkg::PIXEL_BITS-1:0]  y_end;
      logic                            alarm_colour;
      awp_pkg::sample_type             window_max;
      awp_pkg::sample_type             window_min;
      logic                            segment_valid;
      logic                            last_segment;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                               csr_wr_en;
   logic [awp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [awp_pkg::CSR_DATA_BITS-1:0]  csr_wr_data;

   awp_req_if req_ch ();
   awp_rsp_if rsp_ch ();

   // Stimulus and scoreboard storage.
   sample_item_type pending_samples[$];
   segment_type     expected_segments[$];

   // Shadow of the block's history and registers, as of the last accepted sample.
   awp_pkg::sample_type             chart_history [HIST_DEPTH];
   int unsigned                     chart_wr_ptr = 0;
   int unsigned                     chart_fill   = 0;
   logic [awp_pkg::SAMPLE_BITS-1:0] shadow_min_span    = awp_pkg::MIN_SPAN_RESET;
   logic [awp_pkg::LEVEL_BITS-1:0]  shadow_alarm_level = awp_pkg::ALARM_LEVEL_RESET;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;

   autoscaled_waveform_plotter_unit #(
      .DEPTH       (HIST_DEPTH),
      .X_STEP      (X_STEP),
      .PLOT_TOP    (PLOT_TOP),
      .PLOT_HEIGHT (PLOT_HEIGHT)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Scale one stored sample to a screen row: top of plot plus height minus
   // the truncated fraction of the span, wrapped to the pixel width.
   function automatic logic [awp_pkg::PIXEL_BITS-1:0] pixel_row(input int unsigned s,
                                                                 input int unsigned lo,
                                                                 input int unsigned span);
      int unsigned row;
      row = PLOT_TOP + PLOT_HEIGHT - ((s - lo) * PLOT_HEIGHT) / span;
      return row[awp_pkg::PIXEL_BITS-1:0];
   endfunction

   // Store one accepted sample and queue every segment it makes visible.
   task automatic plot_sample(input sample_item_type item);
      int unsigned pos, lo, hi, floor_span, span, xs, xe, p0, p1;
      logic        alarm;
      segment_type seg;
      chart_history[chart_wr_ptr] = item.sample;
      chart_wr_ptr = (chart_wr_ptr + 1) % HIST_DEPTH;
      if (chart_fill < HIST_DEPTH) begin
         chart_fill++;
      end
      lo = SAMPLE_MAX;
      hi = 0;
      for (int i = 0; i < chart_fill; i++) begin
         pos = (chart_wr_ptr + HIST_DEPTH - chart_fill + i) % HIST_DEPTH;
         if (chart_history[pos] < lo) lo = chart_history[pos];
         if (chart_history[pos] > hi) hi = chart_history[pos];
      end
      // A zero floor would divide by zero; the block treats it as one.
      floor_span = (shadow_min_span == 0) ? 1 : shadow_min_span;
      span  = (hi - lo < floor_span) ? floor_span : hi - lo;
      alarm = (item.alert_level >= shadow_alarm_level);

      seg.alarm_colour = alarm;
      seg.window_max   = hi[awp_pkg::SAMPLE_BITS-1:0];
      seg.window_min   = lo[awp_pkg::SAMPLE_BITS-1:0];
      if (chart_fill < 2) begin
         // Lone first sample: extremes only, no line to draw.
         seg.x_start       = '0;
         seg.y_start       = '0;
         seg.x_end         = '0;
         seg.y_end         = '0;
         seg.segment_valid = 1'b0;
         seg.last_segment  = 1'b1;
         expected_segments.push_back(seg);
      end else begin
         for (int i = 0; i + 1 < chart_fill; i++) begin
            p0 = (chart_wr_ptr + HIST_DEPTH - chart_fill + i) % HIST_DEPTH;
            p1 = (p0 + 1) % HIST_DEPTH;
            xs = i * X_STEP;
            xe = (i + 1) * X_STEP;
            seg.x_start       = xs[awp_pkg::PIXEL_BITS-1:0];
            seg.y_start       = pixel_row(chart_history[p0], lo, span);
            seg.x_end         = xe[awp_pkg::X_END_BITS-1:0];
            seg.y_end         = pixel_row(chart_history[p1], lo, span);
            seg.segment_valid = 1'b1;
            seg.last_segment  = (i + 2 == chart_fill);
            expected_segments.push_back(seg);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [11:0] exp_v,
                              input logic [11:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                  act_v);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the oldest pending sample, hold it until accepted, then
   // predict its segments. Gaps between transactions follow send_idle_pct.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            plot_sample(pending_samples[0]);
            void'(pending_samples.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            // Hold the stalled transaction as it is.
         end else if (pending_samples.size() != 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid       <= 1'b1;
            req_ch.sample      <= pending_samples[0].sample;
            req_ch.alert_level <= pending_samples[0].alert_level;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compare each accepted segment with the oldest expectation and
   // stall the result channel according to recv_stall_pct.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      segment_type seg;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_segments.size() == 0) begin
               $display("%0t: unexpected segment transaction, expected none, actual x=%0d",
                        $time, rsp_ch.x_start);
               fail_count++;
            end else begin
               seg = expected_segments.pop_front();
               check_field("x_start",       seg.x_start,       rsp_ch.x_start);
               check_field("y_start",       seg.y_start,       rsp_ch.y_start);
               check_field("x_end",         seg.x_end,         rsp_ch.x_end);
               check_field("y_end",         seg.y_end,         rsp_ch.y_end);
               check_field("alarm_colour",  seg.alarm_colour,  rsp_ch.alarm_colour);
               check_field("window_max",    seg.window_max,    rsp_ch.window_max);
               check_field("window_min",    seg.window_min,    rsp_ch.window_min);
               check_field("segment_valid", seg.segment_valid, rsp_ch.segment_valid);
               check_field("last_segment",  seg.last_segment,  rsp_ch.last_segment);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired, nothing accepted for %0d cycles", $time,
                  quiet_cycles);
         $display("** autoscaled_waveform_plotter_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int clamp_sample(input int v);
      return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
   endfunction

   task automatic push_sample(input int s, input int lvl);
      sample_item_type item;
      item.sample      = s[awp_pkg::SAMPLE_BITS-1:0];
      item.alert_level = lvl[awp_pkg::LEVEL_BITS-1:0];
      pending_samples.push_back(item);
   endtask

   // Write a register only while idle; mirror it in the scoreboard at once.
   task automatic write_csr(input logic [awp_pkg::CSR_INDEX_BITS-1:0] idx,
                            input int data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data[awp_pkg::CSR_DATA_BITS-1:0];
      if (idx == awp_pkg::CSR_MIN_SPAN) begin
         shadow_min_span = data[awp_pkg::SAMPLE_BITS-1:0];
      end else begin
         shadow_alarm_level = data[awp_pkg::LEVEL_BITS-1:0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || expected_segments.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Queue bursts of random shape: full-range noise, small wobble around a
   // level (where the span floor bites), ramps, flat runs and rail-to-rail
   // square waves. Alert levels stay fully random.
   task automatic push_waveform(input int count);
      wave_kind_type kind;
      int level, slope, burst, v;
      level = $urandom_range(SAMPLE_MAX);
      while (count > 0) begin
         kind  = wave_kind_type'($urandom_range(4));
         burst = $urandom_range(4, 20);
         slope = $urandom_range(600) - 300;
         if (burst > count) burst = count;
         for (int j = 0; j < burst; j++) begin
            case (kind)
               WAVE_RANDOM: begin
                  v = $urandom_range(SAMPLE_MAX);
               end
               WAVE_NOISE: begin
                  v = clamp_sample(level + $urandom_range(31) - 16);
               end
               WAVE_RAMP: begin
                  level = clamp_sample(level + slope);
                  v = level;
               end
               WAVE_FLAT: begin
                  v = level;
               end
               default: begin
                  v = (j % 2) ? SAMPLE_MAX : 0;
               end
            endcase
            push_sample(v, $urandom_range(7));
         end
         count -= burst;
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int flat_value;
      csr_wr_en          <= 1'b0;
      csr_index          <= awp_pkg::CSR_MIN_SPAN;
      csr_wr_data        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset register values: lone first sample at full scale,
      // then rail-to-rail steps around the alarm threshold.
      push_sample(SAMPLE_MAX, 7);
      push_sample(0, 0);
      push_sample(0, 2);
      push_sample(0, 3);
      push_sample(2048, 5);
      push_sample(2047, 4);
      wait_idle();

      // Zero span floor and an alarm threshold of zero: every level alarms.
      write_csr(awp_pkg::CSR_MIN_SPAN, 0);
      write_csr(awp_pkg::CSR_ALARM_LEVEL, 0);
      push_sample(1, 0);
      push_sample(4094, 1);
      push_sample(SAMPLE_MAX, 6);
      wait_idle();

      // Widest floor and highest threshold: only level seven alarms.
      write_csr(awp_pkg::CSR_MIN_SPAN, SAMPLE_MAX);
      write_csr(awp_pkg::CSR_ALARM_LEVEL, 7);
      push_sample(SAMPLE_MAX, 6);
      push_sample(100, 7);
      push_sample(0, 1);
      wait_idle();

      // Phase 1, no idling: zero floor with a flat run longer than the
      // history, so the whole window collapses to a zero difference.
      write_csr(awp_pkg::CSR_MIN_SPAN, 0);
      write_csr(awp_pkg::CSR_ALARM_LEVEL, 0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      flat_value = $urandom_range(SAMPLE_MAX);
      for (int i = 0; i < HIST_DEPTH + 2; i++) begin
         push_sample(flat_value, $urandom_range(7));
      end
      push_waveform(ITEMS_PER_RUN - HIST_DEPTH - 2);
      wait_idle();

      // Phase 2, sender mostly idle: floor at full scale.
      write_csr(awp_pkg::CSR_MIN_SPAN, SAMPLE_MAX);
      write_csr(awp_pkg::CSR_ALARM_LEVEL, 7);
      send_idle_pct  = 81;
      recv_stall_pct = 0;
      push_waveform(ITEMS_PER_RUN);
      wait_idle();

      // Phase 3, receiver mostly stalled: smallest legal floor.
      write_csr(awp_pkg::CSR_MIN_SPAN, 1);
      write_csr(awp_pkg::CSR_ALARM_LEVEL, $urandom_range(7));
      send_idle_pct  = 0;
      recv_stall_pct = 81;
      push_waveform(ITEMS_PER_RUN);
      wait_idle();

      // Phase 4, both sides idling: a moderate random floor.
      write_csr(awp_pkg::CSR_MIN_SPAN, $urandom_range(2, 200));
      write_csr(awp_pkg::CSR_ALARM_LEVEL, $urandom_range(7));
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      push_waveform(ITEMS_PER_RUN);
      wait_idle();

      // Let any stray segment surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** autoscaled_waveform_plotter_unit: PASSED **");
      end else begin
         $display("** autoscaled_waveform_plotter_unit: FAILED **");
      end
      $finish;
   end

endmodule
